@@ rtl/core/tsi_pkg.sv @@
// Shared types, constants and codes of the timestamped sample interpolator.
`timescale 1ns / 1ps
`default_nettype none
package tsi_pkg;

	localparam int TIME_W         = 32;
	localparam int POS_W          = 32;
	localparam int FACE_W         = 8;
	localparam int GAP_W          = 16;
	localparam int FRAC_W         = 16;
	localparam int RING_DEPTH_DEF = 16;
	localparam logic [GAP_W-1:0] MIN_GAP_RST = GAP_W'(1);

	// shared subtractor: 33-bit magnitudes plus a sign bit
	localparam int ALU_W  = TIME_W + 2;
	localparam int REM_W  = TIME_W + 1;
	localparam int DIFF_W = POS_W + 1;
	localparam int QUO_W  = FRAC_W + 1;
	localparam int PROD_W = DIFF_W + QUO_W + 1;
	localparam int DCNT_W = $clog2(QUO_W);

	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0] time_us;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [FACE_W-1:0] facing;
	} sample_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_CHK,
		ST_SUBD,
		ST_CMPG,
		ST_SUBN,
		ST_DIV,
		ST_DIFX,
		ST_MULX,
		ST_ADDX,
		ST_DIFY,
		ST_MULY,
		ST_ADDY,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		ALU_NONE,
		ALU_SCAN,
		ALU_DELTA,
		ALU_GAP,
		ALU_OFFSET,
		ALU_DIV,
		ALU_DX,
		ALU_DY
	} alu_sel_t;

	typedef struct packed {
		state_t   st;
		logic     busy;
		logic     rd_en;
		logic     done;
		alu_sel_t alu_sel;
	} ctrl_t;

	typedef struct packed {
		logic query;
		logic empty;
		logic alu_ge;
		logic scan_last;
		logic div_last;
	} status_t;

endpackage
`default_nettype wire

@@ rtl/core/tsi_ring.sv @@
// Sample ring storage: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module tsi_ring import tsi_pkg::*; #(
	parameter int DEPTH = RING_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire sample_t                  wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output sample_t                       rdata
);

	sample_t mem [DEPTH];
	sample_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ rtl/core/tsi_alu.sv @@
// Shared subtract and compare unit used by scan, gap check, divider and deltas.
`timescale 1ns / 1ps
`default_nettype none
module tsi_alu import tsi_pkg::*; (
	input  wire logic [ALU_W-1:0] op_a,
	input  wire logic [ALU_W-1:0] op_b,
	output logic [ALU_W-1:0]      diff,
	output logic                  ge
);

	// operands are sign-extended by one bit, so the top bit is the sign
	assign diff = op_a - op_b;
	assign ge   = ~diff[ALU_W-1];

endmodule
`default_nettype wire

@@ rtl/core/tsi_seq.sv @@
// Query sequencer: walks the ring, then drives divide and interpolation steps.
`timescale 1ns / 1ps
`default_nettype none
module tsi_seq import tsi_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire status_t stat,
	output ctrl_t        ctrl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (stat.query) begin
					state_d = stat.empty ? ST_DONE : ST_RD;
				end
			end
			ST_RD:   state_d = ST_CHK;
			ST_CHK: begin
				if (stat.alu_ge) begin
					state_d = ST_SUBD;
				end else if (stat.scan_last) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_SUBD: state_d = ST_CMPG;
			ST_CMPG: state_d = stat.alu_ge ? ST_DONE : ST_SUBN;
			ST_SUBN: state_d = ST_DIV;
			ST_DIV:  state_d = stat.div_last ? ST_DIFX : ST_DIV;
			ST_DIFX: state_d = ST_MULX;
			ST_MULX: state_d = ST_ADDX;
			ST_ADDX: state_d = ST_DIFY;
			ST_DIFY: state_d = ST_MULY;
			ST_MULY: state_d = ST_ADDY;
			ST_ADDY: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.st      = state_q;
		ctrl.busy    = (state_q != ST_IDLE);
		ctrl.rd_en   = (state_q == ST_RD);
		ctrl.done    = (state_q == ST_DONE);
		ctrl.alu_sel = ALU_NONE;
		unique case (state_q)
			ST_CHK:  ctrl.alu_sel = ALU_SCAN;
			ST_SUBD: ctrl.alu_sel = ALU_DELTA;
			ST_CMPG: ctrl.alu_sel = ALU_GAP;
			ST_SUBN: ctrl.alu_sel = ALU_OFFSET;
			ST_DIV:  ctrl.alu_sel = ALU_DIV;
			ST_DIFX: ctrl.alu_sel = ALU_DX;
			ST_DIFY: ctrl.alu_sel = ALU_DY;
			default: ctrl.alu_sel = ALU_NONE;
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/core/timestamped_sample_interpolator_unit.sv @@
// Top level of the timestamped sample interpolator: ring, sequencer, datapath.
`timescale 1ns / 1ps
`default_nettype none
//
// Channel   Signals                                   Transfer
// --------  ----------------------------------------  -----------------------------
// item in   start, opcode, time_us, pos_x/y, facing   start high while busy low
// result    done, found, out_x, out_y, out_facing     done high for one cycle
// config    cfg_we, cfg_wdata (min_gap)               cfg_we high, any time
//
// A push never raises busy: the sample is written at the transfer edge and
// the next item may follow in the next cycle. A query of an empty ring goes
// straight to its done state. Otherwise the scan reads ring entries one at a
// time through the single read port (k entries read, 1 <= k <= RING_DEPTH),
// then a hit within min_gap returns the later sample and an interpolating hit
// runs the 17-step restoring divider on the shared subtractor. done is high in
// the last busy cycle; the receiver cannot stall it. Reset clears pointers, fill
// count and sequencer and loads min_gap with 1; the ring contents are not cleared.
//
module timestamped_sample_interpolator_unit import tsi_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic                     opcode,
	input  wire logic [TIME_W-1:0]        time_us,
	input  wire logic signed [POS_W-1:0]  pos_x,
	input  wire logic signed [POS_W-1:0]  pos_y,
	input  wire logic [FACE_W-1:0]        facing,
	input  wire logic                     cfg_we,
	input  wire logic [GAP_W-1:0]         cfg_wdata,
	output logic                          done,
	output logic                          found,
	output logic signed [POS_W-1:0]       out_x,
	output logic signed [POS_W-1:0]       out_y,
	output logic [FACE_W-1:0]             out_facing
);

	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam int CNT_W = $clog2(RING_DEPTH + 1);
	localparam int SUM_W = IDX_W + 1;

	ctrl_t   ctrl;
	status_t stat;

	// ring pointers
	logic [IDX_W-1:0] oldest_q;
	logic [CNT_W-1:0] fill_q;
	logic [GAP_W-1:0] min_gap_q;

	// scan state
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] target_q;
	sample_t           prev_q;
	sample_t           late_q;

	// arithmetic state
	logic [TIME_W-1:0]        delta_q;
	logic [REM_W-1:0]         rem_q;
	logic [QUO_W-1:0]         frac_q;
	logic [DCNT_W-1:0]        dcnt_q;
	logic [DIFF_W-1:0]        diff_q;
	logic signed [PROD_W-1:0] prod_q;

	// result registers
	logic              found_q;
	logic [POS_W-1:0]  out_x_q;
	logic [POS_W-1:0]  out_y_q;
	logic [FACE_W-1:0] out_facing_q;

	logic              accept;
	logic              push;
	logic [SUM_W-1:0]  wsum;
	logic [IDX_W-1:0]  waddr;
	logic [IDX_W-1:0]  idx_next;
	sample_t           wdata;
	sample_t           rdata;
	logic [ALU_W-1:0]  alu_a;
	logic [ALU_W-1:0]  alu_b;
	logic [ALU_W-1:0]  alu_diff;
	logic              alu_ge;
	logic [PROD_W-1:0] prod_rnd;
	logic [POS_W-1:0]  lerp_step;

	assign busy   = ctrl.busy;
	assign accept = start & ~ctrl.busy;
	assign push   = accept & (opcode == OP_PUSH);

	// write slot just after the newest sample, wrapping at the ring end
	assign wsum  = SUM_W'(oldest_q) + SUM_W'(fill_q);
	assign waddr = (wsum >= SUM_W'(RING_DEPTH)) ? IDX_W'(wsum - SUM_W'(RING_DEPTH))
	                                            : IDX_W'(wsum);
	assign idx_next = (idx_q == IDX_W'(RING_DEPTH - 1)) ? '0 : idx_q + 1'b1;

	always_comb begin
		wdata.time_us = time_us;
		wdata.x       = pos_x;
		wdata.y       = pos_y;
		wdata.facing  = facing;
	end

	tsi_ring #(
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (push),
		.waddr (waddr),
		.wdata (wdata),
		.re    (ctrl.rd_en),
		.raddr (idx_q),
		.rdata (rdata)
	);

	// operand selection for the shared subtractor
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		unique case (ctrl.alu_sel)
			ALU_NONE: begin
				alu_a = '0;
				alu_b = '0;
			end
			ALU_SCAN: begin
				alu_a = ALU_W'(rdata.time_us);
				alu_b = ALU_W'(target_q);
			end
			ALU_DELTA: begin
				alu_a = ALU_W'(late_q.time_us);
				alu_b = ALU_W'(prev_q.time_us);
			end
			ALU_GAP: begin
				alu_a = ALU_W'(min_gap_q);
				alu_b = ALU_W'(delta_q);
			end
			ALU_OFFSET: begin
				alu_a = ALU_W'(target_q);
				alu_b = ALU_W'(prev_q.time_us);
			end
			ALU_DIV: begin
				// first step takes the integer bit, later ones shift in zeros
				alu_a = (dcnt_q == '0) ? ALU_W'(rem_q) : ALU_W'({rem_q, 1'b0});
				alu_b = ALU_W'(delta_q);
			end
			ALU_DX: begin
				alu_a = ALU_W'($signed(late_q.x));
				alu_b = ALU_W'($signed(prev_q.x));
			end
			ALU_DY: begin
				alu_a = ALU_W'($signed(late_q.y));
				alu_b = ALU_W'($signed(prev_q.y));
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	tsi_alu u_alu (
		.op_a (alu_a),
		.op_b (alu_b),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	always_comb begin
		stat.query     = accept & (opcode == OP_QUERY);
		stat.empty     = (fill_q == '0);
		stat.alu_ge    = alu_ge;
		stat.scan_last = (CNT_W'(cnt_q + 1'b1) == fill_q);
		stat.div_last  = (dcnt_q == DCNT_W'(QUO_W - 1));
	end

	tsi_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// round half up, then keep the integer part (floor of the shift)
	assign prod_rnd  = prod_q + PROD_W'(1 << (FRAC_W - 1));
	assign lerp_step = prod_rnd[FRAC_W +: POS_W];

	// ring pointers and min_gap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q  <= '0;
			fill_q    <= '0;
			min_gap_q <= MIN_GAP_RST;
		end else begin
			if (cfg_we) begin
				min_gap_q <= cfg_wdata;
			end
			if (push) begin
				if (fill_q < CNT_W'(RING_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end else begin
					// full ring: drop the oldest sample
					oldest_q <= (oldest_q == IDX_W'(RING_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (ctrl.st)
			ST_IDLE: begin
				if (stat.query) begin
					idx_q    <= oldest_q;
					cnt_q    <= '0;
					target_q <= time_us;
					// empty ring answers with zeros
					found_q      <= 1'b0;
					out_x_q      <= '0;
					out_y_q      <= '0;
					out_facing_q <= '0;
				end
			end
			ST_CHK: begin
				if (alu_ge) begin
					late_q <= rdata;
					// a hit on the first entry brackets with itself
					if (cnt_q == '0) begin
						prev_q <= rdata;
					end
				end else begin
					prev_q <= rdata;
					cnt_q  <= cnt_q + 1'b1;
					idx_q  <= idx_next;
					// each miss loads its sample, so a miss on the newest returns it as is
					found_q      <= 1'b1;
					out_x_q      <= rdata.x;
					out_y_q      <= rdata.y;
					out_facing_q <= rdata.facing;
				end
			end
			ST_SUBD: begin
				delta_q <= alu_diff[TIME_W-1:0];
			end
			ST_CMPG: begin
				// later sample within min_gap: return it unchanged
				found_q      <= 1'b1;
				out_x_q      <= late_q.x;
				out_y_q      <= late_q.y;
				out_facing_q <= late_q.facing;
			end
			ST_SUBN: begin
				rem_q  <= alu_diff[REM_W-1:0];
				frac_q <= '0;
				dcnt_q <= '0;
			end
			ST_DIV: begin
				rem_q  <= alu_ge ? alu_diff[REM_W-1:0] : alu_a[REM_W-1:0];
				frac_q <= {frac_q[QUO_W-2:0], alu_ge};
				dcnt_q <= dcnt_q + 1'b1;
			end
			ST_DIFX, ST_DIFY: begin
				diff_q <= alu_diff[DIFF_W-1:0];
			end
			ST_MULX, ST_MULY: begin
				prod_q <= $signed(diff_q) * $signed({1'b0, frac_q});
			end
			ST_ADDX: begin
				out_x_q <= prev_q.x + lerp_step;
			end
			ST_ADDY: begin
				out_y_q <= prev_q.y + lerp_step;
			end
			ST_RD, ST_DONE: begin
				// hold
			end
			default: begin
				// hold
			end
		endcase
	end

	assign done       = ctrl.done;
	assign found      = found_q;
	assign out_x      = out_x_q;
	assign out_y      = out_y_q;
	assign out_facing = out_facing_q;

endmodule
`default_nettype wire

@@ rtl/core/tsi_checker.sv @@
// Port-level checker for the timestamped sample interpolator, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module tsi_checker import tsi_pkg::*; (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    start,
	input wire logic                    busy,
	input wire logic                    opcode,
	input wire logic                    done,
	input wire logic                    found,
	input wire logic signed [POS_W-1:0] out_x,
	input wire logic signed [POS_W-1:0] out_y,
	input wire logic [FACE_W-1:0]       out_facing
);

	// a result only appears while a query is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a query");

	// one result per query, then back to idle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	// a push transfer completes without raising busy and without a result
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode == OP_PUSH |=> !busy && !done)
		else $error("push caused busy or a result");

	// a query transfer always makes the block busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode == OP_QUERY |=> busy)
		else $error("query not taken");

	// an empty ring answers with zeros
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> out_x == '0 && out_y == '0 && out_facing == '0)
		else $error("empty answer not zero");

endmodule

bind timestamped_sample_interpolator_unit tsi_checker u_tsi_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.opcode     (opcode),
	.done       (done),
	.found      (found),
	.out_x      (out_x),
	.out_y      (out_y),
	.out_facing (out_facing)
);
`default_nettype wire

@@ tb/tb_timestamped_sample_interpolator_unit.sv @@
// Self-checking testbench for the timestamped sample interpolator unit.
`timescale 1ns / 1ps
module tb_timestamped_sample_interpolator_unit;
	import tsi_pkg::*;

	localparam int DEPTH = RING_DEPTH_DEF;
	// Sized for the worst case per item (longest scan plus divide, plus the
	// longest sender gap), so this leaves a wide margin over ~1000 items.
	localparam int CYCLE_LIMIT = 600000;

	// one command as the sender presents it; settle holds it back until every
	// outstanding answer has come out
	typedef struct {
		bit                settle;
		logic              op;
		logic [TIME_W-1:0] t;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [FACE_W-1:0] f;
	} cmd_t;

	typedef struct {
		logic              found;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [FACE_W-1:0] f;
	} answer_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              opcode = OP_PUSH;
	logic [TIME_W-1:0] time_us = '0;
	logic [POS_W-1:0]  pos_x = '0;
	logic [POS_W-1:0]  pos_y = '0;
	logic [FACE_W-1:0] facing = '0;
	logic              cfg_we = 1'b0;
	logic [GAP_W-1:0]  cfg_wdata = '0;
	wire               busy;
	wire               done;
	wire               found;
	wire [POS_W-1:0]   out_x;
	wire [POS_W-1:0]   out_y;
	wire [FACE_W-1:0]  out_facing;

	timestamped_sample_interpolator_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.time_us    (time_us),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.facing     (facing),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.found      (found),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_facing (out_facing)
	);

	// Commands waiting to be sent, and answers the ring owes us, oldest first.
	cmd_t    cmd_q[$];
	answer_t answer_q[$];

	// Shadow copy of the sample ring and the min_gap register.
	logic [TIME_W-1:0] ring_time [DEPTH];
	logic [POS_W-1:0]  ring_x    [DEPTH];
	logic [POS_W-1:0]  ring_y    [DEPTH];
	logic [FACE_W-1:0] ring_face [DEPTH];
	int unsigned       ring_oldest = 0;
	int unsigned       ring_fill = 0;
	logic [GAP_W-1:0]  gap_model = MIN_GAP_RST;

	// Sender idling: chance per transfer of a gap burst, and cycles left in it.
	int unsigned idle_pct = 0;
	int unsigned gap_left = 0;
	int unsigned mismatch_cnt = 0;
	int unsigned cycle_cnt = 0;

	// Stimulus generator state: current time base, position, recent push times.
	logic [TIME_W-1:0] gen_t = '0;
	logic [POS_W-1:0]  gen_x = '0;
	logic [POS_W-1:0]  gen_y = '0;
	logic [TIME_W-1:0] recent_t[$];

	initial begin
		forever #10 clk = ~clk;
	end

	// x0 + (x1 - x0) * a / 2^16, rounded half up; a carries 16 fraction bits.
	function automatic logic [POS_W-1:0] blend_pos(logic [POS_W-1:0] p0,
			logic [POS_W-1:0] p1, longint a);
		longint diff;
		longint prod;
		diff = longint'($signed(p1)) - longint'($signed(p0));
		prod = diff * a + 32768;
		return POS_W'(longint'($signed(p0)) + (prod >>> 16));
	endfunction

	// Answer a position query against the shadow ring.
	function automatic answer_t lookup_at(logic [TIME_W-1:0] target);
		answer_t         r;
		int unsigned     p;
		int unsigned     prv;
		int unsigned     lat;
		bit              hit;
		longint unsigned n;
		longint unsigned d;
		longint unsigned a;
		r = '{found: 1'b0, x: '0, y: '0, f: '0};
		if (ring_fill == 0)
			return r;
		r.found = 1'b1;
		prv = ring_oldest;
		lat = prv;
		hit = 1'b0;
		// walk from the oldest sample to the first one at or after the target
		for (int unsigned i = 0; i < ring_fill; i++) begin
			p = (ring_oldest + i) % DEPTH;
			if (ring_time[p] >= target) begin
				lat = p;
				hit = 1'b1;
				break;
			end
			prv = p;
		end
		if (!hit) begin
			// nothing late enough: hand back the newest sample as stored
			p = (ring_oldest + ring_fill - 1) % DEPTH;
			r.x = ring_x[p];
			r.y = ring_y[p];
			r.f = ring_face[p];
			return r;
		end
		r.f = ring_face[lat];
		// too close in time (or no earlier sample at all): no blending,
		// compared in 64 bits so the gap never wraps
		if (longint'(ring_time[lat]) <= longint'(ring_time[prv]) + longint'(gap_model)) begin
			r.x = ring_x[lat];
			r.y = ring_y[lat];
			return r;
		end
		d = longint'(ring_time[lat]) - longint'(ring_time[prv]);
		n = longint'(target) - longint'(ring_time[prv]);
		a = (n << FRAC_W) / d;
		if (a > (1 << FRAC_W))
			a = 1 << FRAC_W;
		r.x = blend_pos(ring_x[prv], ring_x[lat], a);
		r.y = blend_pos(ring_y[prv], ring_y[lat], a);
		return r;
	endfunction

	// Write a sample after the newest one; overwrite the oldest once full.
	function automatic void store_sample(cmd_t c);
		int unsigned p;
		p = (ring_oldest + ring_fill) % DEPTH;
		ring_time[p] = c.t;
		ring_x[p] = c.x;
		ring_y[p] = c.y;
		ring_face[p] = c.f;
		if (ring_fill < DEPTH)
			ring_fill++;
		else
			ring_oldest = (ring_oldest + 1) % DEPTH;
	endfunction

	function automatic void add_cmd(logic op, logic [TIME_W-1:0] t, logic [POS_W-1:0] x,
			logic [POS_W-1:0] y, logic [FACE_W-1:0] f, bit settle);
		cmd_t c;
		c = '{settle: settle, op: op, t: t, x: x, y: y, f: f};
		cmd_q = {cmd_q, c};
		if (op == OP_PUSH) begin
			recent_t = {recent_t, t};
			if (recent_t.size() > DEPTH)
				void'(recent_t.pop_front());
		end
	endfunction

	// Occasionally hold a command until the block has drained completely.
	function automatic bit rare_settle();
		return $urandom_range(0, 199) == 0;
	endfunction

	// Advance the generator clock; mix steps inside and well beyond min_gap.
	function automatic void push_next();
		case ($urandom_range(0, 9))
			0, 1:    gen_t = gen_t + $urandom_range(0, 3);
			2:       gen_t = gen_t + $urandom_range(60000, 300000);
			3:       gen_t = gen_t + $urandom;
			default: gen_t = gen_t + $urandom_range(1, 5000);
		endcase
		if ($urandom_range(0, 3) == 0) begin
			gen_x = $urandom;
			gen_y = $urandom;
		end else begin
			gen_x = gen_x + $urandom_range(0, 400000) - 200000;
			gen_y = gen_y + $urandom_range(0, 400000) - 200000;
		end
		add_cmd(OP_PUSH, gen_t, gen_x, gen_y, FACE_W'($urandom), rare_settle());
	endfunction

	// Aim a query near a recently pushed time, or anywhere at all.
	function automatic void query_near();
		logic [TIME_W-1:0] t;
		if (recent_t.size() == 0)
			t = $urandom;
		else
			t = recent_t[$urandom_range(0, recent_t.size() - 1)];
		case ($urandom_range(0, 9))
			0:       t = t;
			1:       t = t + 1;
			2:       t = t - 1;
			3:       t = $urandom;
			4:       t = '0;
			5:       t = '1;
			6, 7:    t = t - $urandom_range(0, 5000);
			default: t = t + $urandom_range(0, 5000);
		endcase
		// position fields ride along as junk; the block must ignore them
		add_cmd(OP_QUERY, t, $urandom, $urandom, FACE_W'($urandom), rare_settle());
	endfunction

	// Queue about n random commands: mostly ordered push runs followed by
	// queries, the rest stray queries and out-of-order pushes.
	task automatic fill_random(int n);
		int made;
		int k;
		made = 0;
		while (made < n) begin
			k = $urandom_range(0, 99);
			if (k < 70) begin
				case ($urandom_range(0, 7))
					0:       gen_t = $urandom;
					1:       gen_t = $urandom_range(0, 1000);
					2:       gen_t = '1 - $urandom_range(0, 400000);
					default: gen_t = gen_t;
				endcase
				repeat ($urandom_range(1, 20)) begin
					push_next();
					made++;
				end
				repeat ($urandom_range(1, 6)) begin
					query_near();
					made++;
				end
			end else if (k < 85) begin
				repeat ($urandom_range(1, 4)) begin
					query_near();
					made++;
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					add_cmd(OP_PUSH, $urandom, $urandom, $urandom, FACE_W'($urandom),
						rare_settle());
					made++;
				end
			end
		end
	endtask

	// Wait until every command is sent and every answer is back, then wait a
	// while longer so the sequencer is surely idle.
	task automatic wait_drained();
		while (cmd_q.size() != 0 || answer_q.size() != 0 || start || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write min_gap while the block is idle and mirror it in the shadow copy.
	task automatic set_min_gap(logic [GAP_W-1:0] v);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		gap_model = v;
	endtask

	// Driver: present the oldest pending command at the falling edge; drop
	// start during gap bursts, or while a settling command waits for the drain.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (gap_left > 0 || cmd_q.size() == 0
				|| (cmd_q[0].settle && answer_q.size() != 0)) begin
			if (gap_left > 0)
				gap_left--;
			start <= 1'b0;
			// toggle the payload while idle; nothing should latch it
			opcode <= 1'($urandom_range(0, 1));
			time_us <= $urandom;
			pos_x <= $urandom;
			pos_y <= $urandom;
			facing <= FACE_W'($urandom);
		end else begin
			start <= 1'b1;
			opcode <= cmd_q[0].op;
			time_us <= cmd_q[0].t;
			pos_x <= cmd_q[0].x;
			pos_y <= cmd_q[0].y;
			facing <= cmd_q[0].f;
		end
	end

	// Monitor: check each done against the oldest answer owed, then account
	// for a command transfer at this edge. Results cannot be stalled, so
	// every done must be taken here.
	always @(posedge clk) begin
		answer_t want;
		cmd_t    sent;
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d commands and %0d answers outstanding",
				$time, cmd_q.size(), answer_q.size());
			$display("== FAIL ==");
			$finish;
		end else if (arst_n) begin
			if (done) begin
				if (answer_q.size() == 0) begin
					$display("%0t: unexpected result found=%0b x=%h y=%h facing=%h",
						$time, found, out_x, out_y, out_facing);
					mismatch_cnt++;
				end else begin
					want = answer_q.pop_front();
					if (found !== want.found) begin
						$display("%0t: found expected %0b actual %0b",
							$time, want.found, found);
						mismatch_cnt++;
					end
					if (out_x !== want.x) begin
						$display("%0t: out_x expected %h actual %h", $time, want.x, out_x);
						mismatch_cnt++;
					end
					if (out_y !== want.y) begin
						$display("%0t: out_y expected %h actual %h", $time, want.y, out_y);
						mismatch_cnt++;
					end
					if (out_facing !== want.f) begin
						$display("%0t: out_facing expected %h actual %h",
							$time, want.f, out_facing);
						mismatch_cnt++;
					end
				end
			end
			if (start && !busy) begin
				sent = cmd_q.pop_front();
				if (sent.op == OP_QUERY)
					answer_q = {answer_q, lookup_at(sent.t)};
				else
					store_sample(sent);
				if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
					gap_left = $urandom_range(1, 18);
			end
		end
	end

	initial begin
		// hold reset low, then release it on a falling edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, min_gap still at its reset value of one.
		idle_pct = 10;
		// empty ring, with all-zero and all-one junk in the position fields
		add_cmd(OP_QUERY, '0, '0, '0, '0, 1'b0);
		add_cmd(OP_QUERY, '1, '1, '1, '1, 1'b0);
		add_cmd(OP_PUSH, 32'd100, 32'h8000_0000, 32'h7FFF_FFFF, 8'h00, 1'b0);
		// first sample already late enough: returned as stored
		add_cmd(OP_QUERY, 32'd50, '1, '0, 8'hFF, 1'b0);
		// nothing late enough: newest sample
		add_cmd(OP_QUERY, 32'd101, '0, '1, 8'h00, 1'b0);
		add_cmd(OP_PUSH, 32'd1100, 32'h7FFF_FFFF, 32'h8000_0000, 8'hFF, 1'b0);
		// blend across the full position range in both directions
		add_cmd(OP_QUERY, 32'd600, '0, '0, '0, 1'b0);
		add_cmd(OP_QUERY, 32'd101, '0, '0, '0, 1'b0);
		add_cmd(OP_QUERY, 32'd1099, '0, '0, '0, 1'b0);
		add_cmd(OP_QUERY, 32'd1100, '0, '0, '0, 1'b0);
		// one microsecond apart: inside min_gap, later sample returned
		add_cmd(OP_PUSH, 32'd1101, 32'h0000_0000, 32'h0000_0000, 8'h5A, 1'b0);
		add_cmd(OP_QUERY, 32'd1101, '0, '0, '0, 1'b0);
		// out-of-order push: scan order decides
		add_cmd(OP_PUSH, 32'd50, 32'h1234_5678, 32'hEDCB_A988, 8'hA5, 1'b0);
		add_cmd(OP_QUERY, 32'd1200, '0, '0, '0, 1'b0);
		add_cmd(OP_QUERY, 32'd75, '0, '0, '0, 1'b0);
		// top of the time range, gap computed without wrap
		add_cmd(OP_PUSH, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 8'hC3, 1'b0);
		add_cmd(OP_QUERY, 32'hFFFF_FFFE, '0, '0, '0, 1'b0);
		// hold the sender until the block has gone quiet
		add_cmd(OP_QUERY, 32'hFFFF_FFFF, '0, '0, '0, 1'b1);
		add_cmd(OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 8'h3C, 1'b0);
		add_cmd(OP_QUERY, 32'hFFFF_FFFF, '0, '0, '0, 1'b0);
		add_cmd(OP_QUERY, 32'h0000_0000, '0, '0, '0, 1'b0);

		// Random phases across min_gap settings, extremes included.
		set_min_gap('0);
		idle_pct = 15;
		fill_random(160);
		set_min_gap('1);
		idle_pct = 30;
		fill_random(160);
		set_min_gap(GAP_W'(1));
		idle_pct = 0;
		fill_random(160);
		set_min_gap(GAP_W'($urandom));
		idle_pct = 10;
		fill_random(160);
		set_min_gap(GAP_W'(300));
		idle_pct = 20;
		fill_random(150);
		// last stretch runs back to back with no sender gaps
		set_min_gap(GAP_W'(16));
		idle_pct = 0;
		fill_random(160);

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/tsi_pkg.sv
rtl/core/tsi_ring.sv
rtl/core/tsi_alu.sv
rtl/core/tsi_seq.sv
rtl/core/timestamped_sample_interpolator_unit.sv
rtl/core/tsi_checker.sv
tb/tb_timestamped_sample_interpolator_unit.sv
